// ----- rtl/tma_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tma_pkg: shared types and constants of the trimmed-mean analog input.
// Holds the controller/datapath handshake structs and the fixed limits.
// ----------------------------------------------------------------------------
package tma_pkg;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVER  = 2'd1;
  localparam logic [1:0] ST_UNDER = 2'd2;
  localparam logic [1:0] ST_FEW   = 2'd3;

  localparam logic [19:0] OVER_MV    = 20'd10250;
  localparam logic [19:0] UNDER_MV   = 20'd100;
  localparam logic [15:0] LOOP_ZERO  = 16'd2000;
  localparam logic [18:0] PCT_FULL   = 19'd10000;
  localparam logic [19:0] GAIN_RESET = 20'd10560;

  localparam logic [1:0] REG_GAIN   = 2'd0;
  localparam logic [1:0] REG_THLOW  = 2'd1;
  localparam logic [1:0] REG_THHIGH = 2'd2;
  localparam logic [1:0] REG_LOOP   = 2'd3;

  typedef struct packed {
    logic insert;
    logic capture;
    logic drain;
    logic div_step;
    logic mul;
    logic fin;
  } tma_cmd_t;

  typedef struct packed {
    logic few;
    logic drain_done;
    logic div_done;
  } tma_sts_t;

  typedef struct packed {
    logic [19:0] gain_q16;
    logic [15:0] threshold_low_mv;
    logic [15:0] threshold_high_mv;
    logic        loop_mode;
  } tma_cfg_t;

endpackage

// ----- rtl/tma_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tma_if: valid/ready channels of the trimmed-mean analog input.
// One interface for the sample stream, one for the result stream.
// ----------------------------------------------------------------------------
interface tma_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample;
  logic        last;
  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);
endinterface

interface tma_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] raw_mean;
  logic [15:0] voltage_mv;
  logic [16:0] current_ua;
  logic [13:0] percent_centi;
  modport source (output valid, output status, output raw_mean, output voltage_mv,
                  output current_ua, output percent_centi, input ready);
  modport sink (input valid, input status, input raw_mean, input voltage_mv,
                input current_ua, input percent_centi, output ready);
endinterface

// ----- rtl/trimmed_mean_analog_input.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trimmed_mean_analog_input: trimmed-mean filter for one ADC channel.
// Sorts a window of samples, averages its middle third and scales it.
// ----------------------------------------------------------------------------
// Usage: raw samples arrive on in_ch, one per transfer; the transfer with
// last set closes the window and yields exactly one result on out_ch.
// Each sample is inserted into a sorted cell chain as it is accepted, so
// samples of a window stream at one per cycle. Samples past WINDOW are
// dropped, but a dropped sample carrying last still closes the window.
// After last the block drains the chain, runs a restoring divider one
// quotient bit per cycle, does the multiply step and then the load cycle,
// and in_ch.ready is low meanwhile.
// A window shorter than three samples skips straight to the load cycle.
// The result sits in an output register, so a stalled receiver only holds
// the next result back; the next window is collected in the meantime, and
// if that window closes first, the load cycle waits with in_ch.ready low
// until the output register is free.
// Reset clears the sample count, the output valid and the registers to
// their defaults; the APB port writes registers at 4*i and reads them back.
// ----------------------------------------------------------------------------
module trimmed_mean_analog_input
  import tma_pkg::*;
#(
  parameter int WINDOW = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  tma_in_if.sink      in_ch,
  tma_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  tma_cfg_t cfg_r;
  tma_cmd_t cmd;
  tma_sts_t sts;
  logic [1:0] reg_sel;

  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[3:2];

  // Register writes complete in the access phase of an APB transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_q16          <= GAIN_RESET;
      cfg_r.threshold_low_mv  <= '0;
      cfg_r.threshold_high_mv <= '0;
      cfg_r.loop_mode         <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (reg_sel)
        REG_GAIN:   cfg_r.gain_q16          <= cfg_pwdata[19:0];
        REG_THLOW:  cfg_r.threshold_low_mv  <= cfg_pwdata[15:0];
        REG_THHIGH: cfg_r.threshold_high_mv <= cfg_pwdata[15:0];
        REG_LOOP:   cfg_r.loop_mode         <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_GAIN:   cfg_prdata = {12'd0, cfg_r.gain_q16};
      REG_THLOW:  cfg_prdata = {16'd0, cfg_r.threshold_low_mv};
      REG_THHIGH: cfg_prdata = {16'd0, cfg_r.threshold_high_mv};
      REG_LOOP:   cfg_prdata = {31'd0, cfg_r.loop_mode};
      default:    cfg_prdata = '0;
    endcase
  end

  tma_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tma_dp #(.WINDOW(WINDOW)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .sample        (in_ch.sample),
    .cfg           (cfg_r),
    .cmd           (cmd),
    .sts           (sts),
    .status        (out_ch.status),
    .raw_mean      (out_ch.raw_mean),
    .voltage_mv    (out_ch.voltage_mv),
    .current_ua    (out_ch.current_ua),
    .percent_centi (out_ch.percent_centi)
  );

endmodule

// ----- rtl/tma_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tma_ctrl: sequencer of the trimmed-mean analog input.
// Collect, drain, divide, scale, load; under three samples only collect, load.
// ----------------------------------------------------------------------------
module tma_ctrl
  import tma_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_last,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  tma_sts_t sts,
  output tma_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DRAIN = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       acc;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign acc       = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          cmd.insert = 1'b1;
          if (in_last) begin
            cmd.capture = 1'b1;
            state_nxt   = sts.few ? S_FIN : S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        cmd.drain = 1'b1;
        if (sts.drain_done) state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.fin       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- rtl/tma_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tma_dp: datapath of the trimmed-mean analog input.
// Insertion-sorting cell chain, drain accumulator, serial divider, scaler.
// ----------------------------------------------------------------------------
module tma_dp
  import tma_pkg::*;
#(
  parameter int WINDOW = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [15:0]  sample,
  input  tma_cfg_t     cfg,
  input  tma_cmd_t     cmd,
  output tma_sts_t     sts,
  output logic [1:0]   status,
  output logic [15:0]  raw_mean,
  output logic [15:0]  voltage_mv,
  output logic [16:0]  current_ua,
  output logic [13:0]  percent_centi
);

  localparam int CW = $clog2(WINDOW + 1);
  localparam int SW = 16 + CW;
  localparam int KW = $clog2(SW);

  logic [15:0]   cell_r [WINDOW];
  logic [WINDOW-1:0] gt;
  logic [CW-1:0] cnt_r, n_r, third_r, idx_r, n_nxt;
  logic [CW+7:0] third_prod;
  logic [SW-1:0] sum_r, q_r;
  logic [CW:0]   rem_r, rem_sh;
  logic [KW-1:0] k_r;
  logic          short_r;
  logic [35:0]   prod_r;
  logic [19:0]   mv;
  logic [15:0]   mv_sat;
  logic [18:0]   pct_raw, pct_clip;
  logic          over, under;
  logic          room;

  assign room  = (cnt_r < CW'(WINDOW));
  assign n_nxt = room ? cnt_r + CW'(1) : cnt_r;
  // n / 3 by reciprocal, exact for every window up to 256.
  assign third_prod = {8'd0, n_nxt} * (CW + 8)'(171);

  assign sts.few        = (n_nxt < CW'(3));
  assign sts.drain_done = (idx_r == n_r - CW'(1));
  assign sts.div_done   = (k_r == KW'(SW - 1));

  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      gt[i] = (CW'(i) < cnt_r) && (cell_r[i] > sample);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < WINDOW; i++) begin
      if (cmd.insert && room && (CW'(i) <= cnt_r)) begin
        if (i > 0 && gt[(i > 0) ? i - 1 : 0]) cell_r[i] <= cell_r[(i > 0) ? i - 1 : 0];
        else if (gt[i] || CW'(i) == cnt_r) cell_r[i] <= sample;
      end else if (cmd.drain && i < WINDOW - 1) begin
        cell_r[i] <= cell_r[(i < WINDOW - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.capture) begin
      cnt_r <= '0;
    end else if (cmd.insert && room) begin
      cnt_r <= cnt_r + CW'(1);
    end
  end

  assign rem_sh = {rem_r[CW-1:0], sum_r[SW-1]};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      n_r     <= n_nxt;
      third_r <= {1'b0, third_prod[CW+7:9]};
      short_r <= sts.few;
      idx_r   <= '0;
      sum_r   <= '0;
      rem_r   <= '0;
      q_r     <= '0;
      k_r     <= '0;
    end else if (cmd.drain) begin
      idx_r <= idx_r + CW'(1);
      if (idx_r >= third_r && idx_r < (third_r << 1)) begin
        sum_r <= sum_r + SW'(cell_r[0]);
      end
    end else if (cmd.div_step) begin
      k_r   <= k_r + KW'(1);
      sum_r <= sum_r << 1;
      if (rem_sh >= {1'b0, third_r}) begin
        rem_r <= rem_sh - {1'b0, third_r};
        q_r   <= {q_r[SW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        q_r   <= {q_r[SW-2:0], 1'b0};
      end
    end
    if (cmd.mul) prod_r <= {20'd0, q_r[15:0]} * {16'd0, cfg.gain_q16};
  end

  assign mv     = prod_r[35:16];
  assign mv_sat = (mv > 20'd65535) ? 16'hFFFF : mv[15:0];
  assign over   = (mv > OVER_MV) ||
                  ((cfg.threshold_high_mv != 16'd0) && (mv > {4'd0, cfg.threshold_high_mv}));
  assign under  = (cfg.loop_mode && (mv < UNDER_MV)) || (mv < {4'd0, cfg.threshold_low_mv});

  always_comb begin
    if (cfg.loop_mode) begin
      pct_raw = (mv_sat > LOOP_ZERO) ? ({3'd0, mv_sat - LOOP_ZERO} * 19'd5) >> 2 : 19'd0;
    end else begin
      pct_raw = {3'd0, mv_sat};
    end
    pct_clip = (pct_raw > PCT_FULL) ? PCT_FULL : pct_raw;
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      if (short_r) begin
        status        <= ST_FEW;
        raw_mean      <= '0;
        voltage_mv    <= '0;
        current_ua    <= '0;
        percent_centi <= '0;
      end else begin
        raw_mean   <= q_r[15:0];
        voltage_mv <= mv_sat;
        if (over) status <= ST_OVER;
        else if (under) status <= ST_UNDER;
        else status <= ST_OK;
        if (over || under) begin
          current_ua    <= '0;
          percent_centi <= '0;
        end else begin
          current_ua    <= {mv_sat, 1'b0};
          percent_centi <= pct_clip[13:0];
        end
      end
    end
  end

endmodule

// ----- rtl/tma_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tma_checker: port-level checks of the trimmed-mean analog input.
// Result consistency and output stall behavior, bound to the top level.
// ----------------------------------------------------------------------------
module tma_checker
  import tma_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [15:0] raw_mean,
  input logic [15:0] voltage_mv,
  input logic [16:0] current_ua,
  input logic [13:0] percent_centi
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(voltage_mv) && $stable(status))
    else $error("result changed while stalled");

  a_few: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_FEW |-> raw_mean == 16'd0 && voltage_mv == 16'd0)
    else $error("short window with nonzero fields");

  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_OK |-> current_ua == 17'd0 && percent_centi == 14'd0)
    else $error("error result with nonzero current or percent");

  a_cur: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_OK |-> current_ua == {voltage_mv, 1'b0} &&
      percent_centi <= 14'd10000)
    else $error("ok result inconsistent");

endmodule

bind trimmed_mean_analog_input tma_checker u_tma_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .status        (out_ch.status),
  .raw_mean      (out_ch.raw_mean),
  .voltage_mv    (out_ch.voltage_mv),
  .current_ua    (out_ch.current_ua),
  .percent_centi (out_ch.percent_centi)
);

// ----- verif/tb_trimmed_mean_analog_input.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_trimmed_mean_analog_input: self-checking bench of the trimmed-mean input.
// Streams sample windows through in_ch, predicts untyped window results with
// behavioral sort-and-average model, compares all on out_ch field by field.
// Registers are reprogrammed over APB between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_trimmed_mean_analog_input;
  import tma_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] raw_mean;
    logic [15:0] voltage_mv;
    logic [16:0] current_ua;
    logic [13:0] percent_centi;
  } window_result_t;

  // One row of the directed table: sample, last flag, and optionally a
  // hand-typed result for the cases that can be read off directly.
  typedef struct packed {
    logic [15:0]    sample;
    logic           last;
    logic           typed;
    window_result_t result;
  } stim_row_t;

  localparam int WIN = 32;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk;
  logic rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  tma_in_if  in_ch ();
  tma_out_if out_ch ();

  trimmed_mean_analog_input #(.WINDOW(WIN)) u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Shadow copy of the register file and the window being collected.
  tma_cfg_t       shadow_cfg;
  logic [15:0]    window_buf[WIN];
  int             window_fill;
  window_result_t pending_results[$];
  int             mismatch_count;
  int             idle_cycles;
  int             send_idle_pct;
  int             recv_idle_pct;

  // A typed result waiting for the last sample of its directed row.
  logic           typed_pending;
  window_result_t typed_value;

  // Predicts the result of a closed window from the shadow registers.
  function automatic window_result_t predict_window(int n);
    logic [15:0] sorted[WIN];
    logic [15:0] v;
    int j, third;
    logic [31:0] sum;
    logic [15:0] mean;
    logic [39:0] mv;
    logic [15:0] mv_sat;
    logic [31:0] pct;
    window_result_t r;
    r = '0;
    if (n < 3) begin
      r.status = ST_FEW;
      return r;
    end
    for (int i = 0; i < n; i++) begin
      v = window_buf[i];
      j = i;
      while (j > 0 && sorted[j-1] > v) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = v;
    end
    third = n / 3;
    sum = 0;
    for (int i = third; i < 2 * third; i++) sum += sorted[i];
    mean = 16'(sum / third);
    mv = (40'(mean) * 40'(shadow_cfg.gain_q16)) >> 16;
    mv_sat = (mv > 40'd65535) ? 16'hFFFF : mv[15:0];
    if (mv > 40'(OVER_MV) ||
        (shadow_cfg.threshold_high_mv != 0 && mv > 40'(shadow_cfg.threshold_high_mv)))
      r.status = ST_OVER;
    else if ((shadow_cfg.loop_mode && mv < 40'(UNDER_MV)) ||
             mv < 40'(shadow_cfg.threshold_low_mv))
      r.status = ST_UNDER;
    else
      r.status = ST_OK;
    r.raw_mean = mean;
    r.voltage_mv = mv_sat;
    if (r.status == ST_OK) begin
      r.current_ua = {mv_sat, 1'b0};
      if (shadow_cfg.loop_mode)
        pct = (mv_sat > LOOP_ZERO) ? ((32'(mv_sat) - 32'(LOOP_ZERO)) * 5) / 4 : 0;
      else
        pct = 32'(mv_sat);
      if (pct > 32'(PCT_FULL)) pct = 32'(PCT_FULL);
      r.percent_centi = pct[13:0];
    end
    return r;
  endfunction

  // Tracks every accepted sample; a last closes the window and queues the
  // expected result, typed or predicted. Samples beyond the window size are
  // dropped.
  function automatic void track_sample(logic [15:0] s, logic l);
    if (window_fill < WIN) begin
      window_buf[window_fill] = s;
      window_fill++;
    end
    if (l) begin
      if (typed_pending) begin
        pending_results.push_back(typed_value);
        typed_pending = 1'b0;
      end else begin
        pending_results.push_back(predict_window(window_fill));
      end
      window_fill = 0;
    end
  endfunction

  // Input monitor, result checker and the watchdog on stalled progress.
  always @(posedge clk) begin
    window_result_t got;
    window_result_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) track_sample(in_ch.sample, in_ch.last);
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.status, out_ch.raw_mean, out_ch.voltage_mv,
                out_ch.current_ua, out_ch.percent_centi};
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result transfer: %p", got);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("result differs: expected %p, got %p", want, got);
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("trimmed_mean_analog_input: mismatch");
      $finish;
    end
  end

  // The receiver stalls at random with the current idle percentage.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Sends one sample; it may idle first, then holds valid until accepted.
  task automatic send_sample(logic [15:0] s, logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample <= s;
    in_ch.last <= l;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic pause_inputs();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every expected result is in, then lets the block settle.
  task automatic drain_results();
    pause_inputs();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // APB write: setup cycle, then the access cycle in which it takes effect.
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_GAIN:   shadow_cfg.gain_q16 = value[19:0];
      REG_THLOW:  shadow_cfg.threshold_low_mv = value[15:0];
      REG_THHIGH: shadow_cfg.threshold_high_mv = value[15:0];
      default:    shadow_cfg.loop_mode = value[0];
    endcase
  endtask

  task automatic program_regs(logic [19:0] gain, logic [15:0] lo, logic [15:0] hi,
                              logic loop_sel);
    write_reg(REG_GAIN, 32'(gain));
    write_reg(REG_THLOW, 32'(lo));
    write_reg(REG_THHIGH, 32'(hi));
    write_reg(REG_LOOP, 32'(loop_sel));
  endtask

  // Random sample biased toward the extremes so that every bit toggles
  // and the range limits are hit from both sides.
  function automatic logic [15:0] rand_sample();
    case ($urandom_range(5))
      0: return 16'hFFFF;
      1: return 16'h0000;
      2: return 16'($urandom_range(255));
      default: return 16'($urandom);
    endcase
  endfunction

  // Sends one window; most are short, a few fill or overflow the store.
  task automatic send_window();
    int len;
    int pick;
    logic [15:0] base;
    pick = $urandom_range(19);
    if (pick == 0) len = $urandom_range(40, 33);
    else if (pick == 1) len = WIN;
    else if (pick == 2) len = $urandom_range(2, 1);
    else len = $urandom_range(12, 3);
    base = rand_sample();
    for (int i = 0; i < len; i++) begin
      // Clustered windows keep the mean in a useful range around base.
      if ($urandom_range(3) == 0) send_sample(rand_sample(), i == len - 1);
      else send_sample(base ^ 16'($urandom_range(63)), i == len - 1);
    end
  endtask

  // Directed table: short windows, the extremes and an unsorted window, then
  // an overflowed one. Rows with typed set carry a result read off the spec.
  stim_row_t directed_rows[$];

  task automatic add_row(logic [15:0] s, logic l, logic typed, window_result_t r);
    directed_rows.push_back('{s, l, typed, r});
  endtask

  initial begin
    window_result_t few_res;
    window_result_t zero_res;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    in_ch.last = 1'b0;
    out_ch.ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    shadow_cfg = '{GAIN_RESET, 16'd0, 16'd0, 1'b0};
    window_fill = 0;
    mismatch_count = 0;
    idle_cycles = 0;
    typed_pending = 1'b0;
    typed_value = '0;
    send_idle_pct = 35;
    recv_idle_pct = 81;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    few_res = '0;
    few_res.status = ST_FEW;
    zero_res = '0;
    zero_res.status = ST_OK;
    // A lone last sample, and two samples: too few for a trimmed mean.
    add_row(16'hFFFF, 1'b1, 1'b1, few_res);
    add_row(16'h0000, 1'b0, 1'b0, '0);
    add_row(16'hFFFF, 1'b1, 1'b1, few_res);
    // Three zeros: mean zero, everything zero and status ok at reset config.
    add_row(16'h0000, 1'b0, 1'b0, '0);
    add_row(16'h0000, 1'b0, 1'b0, '0);
    add_row(16'h0000, 1'b1, 1'b1, zero_res);
    // Full scale: over-range at the reset gain.
    add_row(16'hFFFF, 1'b0, 1'b0, '0);
    add_row(16'hFFFF, 1'b0, 1'b0, '0);
    add_row(16'hFFFF, 1'b1, 1'b0, '0);
    // Unsorted six-sample window with outliers at both ends.
    add_row(16'hFFFF, 1'b0, 1'b0, '0);
    add_row(16'd1000, 1'b0, 1'b0, '0);
    add_row(16'd0,    1'b0, 1'b0, '0);
    add_row(16'd3000, 1'b0, 1'b0, '0);
    add_row(16'd2000, 1'b0, 1'b0, '0);
    add_row(16'h5555, 1'b1, 1'b0, '0);
    foreach (directed_rows[i]) begin
      if (directed_rows[i].typed) begin
        typed_value = directed_rows[i].result;
        typed_pending = 1'b1;
      end
      send_sample(directed_rows[i].sample, directed_rows[i].last);
    end
    // Overflowed window: samples past the store size are dropped, and the
    // dropped final one still closes the window.
    for (int i = 0; i < WIN + 3; i++) send_sample(16'(i * 1500), i == WIN + 2);
    drain_results();

    // Random phases over several register settings, extremes included.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: program_regs(20'd10560, 16'd0, 16'd0, 1'b1);
        1: program_regs(20'hFFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        2: program_regs(20'd0, 16'd0, 16'd0, 1'b1);
        3: program_regs(20'($urandom), 16'($urandom_range(3000)),
                        16'($urandom_range(20000, 3000)), 1'($urandom));
        4: program_regs(20'd20000, 16'd500, 16'd9000, 1'b1);
        default: program_regs(20'd10560, 16'd0, 16'd0, 1'b0);
      endcase
      if (phase == 2) begin
        send_idle_pct = 81;
        recv_idle_pct = 35;
      end else if (phase == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int w = 0; w < 6; w++) send_window();
      drain_results();
    end

    if (mismatch_count == 0) begin
      $display("trimmed_mean_analog_input: match");
    end else begin
      $display("trimmed_mean_analog_input: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/tma_pkg.sv
rtl/tma_if.sv
rtl/tma_ctrl.sv
rtl/tma_dp.sv
rtl/trimmed_mean_analog_input.sv
rtl/tma_checker.sv
verif/tb_trimmed_mean_analog_input.sv
